### design/rmd160_pkg.sv
// Package for the RIPEMD-160 hash core: sequencer states, constants, step tables, round functions.
package rmd160_pkg;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LOAD,
		S_COMP,
		S_FINAL,
		S_OUT
	} state_t;

	localparam int NUM_STEPS = 80;
	localparam int NUM_CV    = 5;

	localparam logic [31:0] IV [NUM_CV] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] KL [NUM_CV] = '{
		32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hA953FD4E
	};
	localparam logic [31:0] KR [NUM_CV] = '{
		32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h7A6D76E9, 32'h00000000
	};

	localparam logic [31:0] PAD_BYTE_WORD = 32'h00000080;
	localparam logic [7:0]  PAD_BYTE      = 8'h80;

	// message word selection, left and right lines
	localparam logic [3:0] WL [NUM_STEPS] = '{
		4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
		4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
		4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
		4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
		4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
		4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
		4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
		4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
	};
	localparam logic [3:0] WR [NUM_STEPS] = '{
		4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
		4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
		4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
		4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
		4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
		4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
		4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
		4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
		4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
		4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
	};

	// rotate amounts, left and right lines
	localparam logic [3:0] SL [NUM_STEPS] = '{
		4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
		4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
		4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
		4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
		4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
		4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
		4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
		4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
		4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
		4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
	};
	localparam logic [3:0] SR [NUM_STEPS] = '{
		4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
		4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
		4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
		4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
		4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
		4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
		4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
		4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
		4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
		4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
	};

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] d;
		d = {v, v} << s;
		return d[63:32];
	endfunction

	function automatic logic [31:0] mix_fn(input logic [2:0] rnd, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z);
		logic [31:0] r;
		case (rnd)
			3'd0: r = x ^ y ^ z;
			3'd1: r = (x & y) | (~x & z);
			3'd2: r = (x | ~y) ^ z;
			3'd3: r = (x & z) | (y & ~z);
			default: r = x ^ (y | ~z);
		endcase
		return r;
	endfunction

endpackage

### design/ripemd160_hash.sv
// RIPEMD-160 hash core: word buffer, padding sequencer and shared two-line round unit.
// Message words are taken one per cycle while idle; each full 16-word block then runs
//   a buffer read prime, 80 steps at one per cycle and a chaining add.
// Message words are stalled while a block runs through the single round unit.
// Padding pushes one word per cycle; the five digest words follow, one per accepted word.
// Reset: async active low; chaining words load the initial value, counters and flags clear.
module ripemd160_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        final_word
);
	import rmd160_pkg::*;

	localparam logic [3:0] FILL_LAST = 4'd15;
	localparam logic [3:0] FILL_LEN  = 4'd14;
	localparam logic [6:0] STEP_LAST = 7'(NUM_STEPS - 1);
	localparam logic [2:0] IDX_LAST  = 3'(NUM_CV - 1);

	state_t state_q, state_nxt;

	// block buffer: one write port, two registered read ports
	logic [31:0] blk_mem [16];
	logic [31:0] xl_q, xr_q;
	logic [3:0]  rd_l_addr, rd_r_addr;
	logic [6:0]  rd_step;

	logic [3:0]  fill_q;
	logic [60:0] msg_bytes_q;
	logic        pad_q;      // padding in progress
	logic        need80_q;   // pad byte still owed as its own word
	logic        lenhi_q;    // next pad word is the high length word
	logic        done_q;     // last block pushed, digest follows

	logic [31:0] cv_q [NUM_CV];
	logic [2:0]  idx_q;

	// working variables of both lines
	logic [31:0] al_q, bl_q, cl_q, dl_q, el_q;
	logic [31:0] ar_q, br_q, cr_q, dr_q, er_q;
	logic [6:0]  step_q;

	logic        msg_acc, dig_acc;
	logic        push_en;
	logic [31:0] push_data;
	logic [2:0]  n_sat;
	logic [2:0]  n_add;
	logic [31:0] last_word;
	logic [63:0] bit_len;

	logic [2:0]  gl, gr;
	logic [31:0] tl, tr, nl, nr;

	assign msg_acc = msg_valid && !msg_stall;
	assign dig_acc = dig_valid && !dig_stall;

	// byte count only matters on the last word; above four means four
	assign n_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
	assign n_add = last ? n_sat : 3'd4;
	assign bit_len = {msg_bytes_q, 3'b000};

	// last word: keep the valid bytes, pad byte right after them, zeros above
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < n_sat)
				last_word[8*i +: 8] = data_word[8*i +: 8];
			else if (3'(i) == n_sat)
				last_word[8*i +: 8] = PAD_BYTE;
			else
				last_word[8*i +: 8] = 8'h00;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (msg_acc) begin
					if (fill_q == FILL_LAST)
						state_nxt = S_LOAD;
					else if (last)
						state_nxt = S_PAD;
				end
			end
			S_PAD: begin
				if (fill_q == FILL_LAST)
					state_nxt = S_LOAD;
			end
			S_LOAD: state_nxt = S_COMP;
			S_COMP: begin
				if (step_q == STEP_LAST)
					state_nxt = S_FINAL;
			end
			S_FINAL: begin
				if (done_q)
					state_nxt = S_OUT;
				else if (pad_q)
					state_nxt = S_PAD;
				else
					state_nxt = S_IDLE;
			end
			S_OUT: begin
				if (dig_acc && idx_q == IDX_LAST)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		msg_stall = 1'b1;
		dig_valid = 1'b0;
		push_en   = 1'b0;
		push_data = 32'h0;
		rd_step   = 7'd0;
		case (state_q)
			S_IDLE: begin
				msg_stall = 1'b0;
				push_en   = msg_valid;
				push_data = (last && n_sat != 3'd4) ? last_word : data_word;
			end
			S_PAD: begin
				push_en = 1'b1;
				if (need80_q)
					push_data = PAD_BYTE_WORD;
				else if (lenhi_q)
					push_data = bit_len[63:32];
				else if (fill_q == FILL_LEN)
					push_data = bit_len[31:0];
				else
					push_data = 32'h0;
			end
			S_LOAD: rd_step = 7'd0;
			S_COMP: rd_step = (step_q == STEP_LAST) ? step_q : step_q + 7'd1;
			S_OUT:  dig_valid = 1'b1;
			default: ;
		endcase
	end

	assign rd_l_addr = WL[rd_step];
	assign rd_r_addr = WR[rd_step];

	always_ff @(posedge clk) begin
		if (push_en)
			blk_mem[fill_q] <= push_data;
		xl_q <= blk_mem[rd_l_addr];
		xr_q <= blk_mem[rd_r_addr];
	end

	// one step of each line
	assign gl = step_q[6:4];
	assign gr = 3'd4 - gl;
	assign tl = al_q + mix_fn(gl, bl_q, cl_q, dl_q) + xl_q + KL[gl];
	assign tr = ar_q + mix_fn(gr, br_q, cr_q, dr_q) + xr_q + KR[gl];
	assign nl = rotl32(tl, {1'b0, SL[step_q]}) + el_q;
	assign nr = rotl32(tr, {1'b0, SR[step_q]}) + er_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				al_q <= cv_q[0]; bl_q <= cv_q[1]; cl_q <= cv_q[2];
				dl_q <= cv_q[3]; el_q <= cv_q[4];
				ar_q <= cv_q[0]; br_q <= cv_q[1]; cr_q <= cv_q[2];
				dr_q <= cv_q[3]; er_q <= cv_q[4];
			end
			S_COMP: begin
				al_q <= el_q; el_q <= dl_q; dl_q <= rotl32(cl_q, 5'd10);
				cl_q <= bl_q; bl_q <= nl;
				ar_q <= er_q; er_q <= dr_q; dr_q <= rotl32(cr_q, 5'd10);
				cr_q <= br_q; br_q <= nr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= 4'd0;
			msg_bytes_q <= 61'd0;
			pad_q       <= 1'b0;
			need80_q    <= 1'b0;
			lenhi_q     <= 1'b0;
			done_q      <= 1'b0;
			idx_q       <= 3'd0;
			step_q      <= 7'd0;
			for (int k = 0; k < NUM_CV; k++)
				cv_q[k] <= IV[k];
		end else begin
			state_q <= state_nxt;
			if (push_en)
				fill_q <= fill_q + 4'd1;   // wraps to zero on a full block
			if (msg_acc) begin
				msg_bytes_q <= msg_bytes_q + {58'd0, n_add};
				if (last) begin
					pad_q    <= 1'b1;
					need80_q <= (n_sat == 3'd4);
				end
			end
			if (state_q == S_PAD) begin
				if (need80_q)
					need80_q <= 1'b0;
				else if (lenhi_q) begin
					lenhi_q <= 1'b0;
					done_q  <= 1'b1;
				end else if (fill_q == FILL_LEN)
					lenhi_q <= 1'b1;
			end
			case (state_q)
				S_LOAD: step_q <= 7'd0;
				S_COMP: step_q <= step_q + 7'd1;
				default: ;
			endcase
			if (state_q == S_FINAL) begin
				cv_q[0] <= cv_q[1] + cl_q + dr_q;
				cv_q[1] <= cv_q[2] + dl_q + er_q;
				cv_q[2] <= cv_q[3] + el_q + ar_q;
				cv_q[3] <= cv_q[4] + al_q + br_q;
				cv_q[4] <= cv_q[0] + bl_q + cr_q;
			end
			if (dig_acc) begin
				if (idx_q == IDX_LAST) begin
					idx_q       <= 3'd0;
					msg_bytes_q <= 61'd0;
					pad_q       <= 1'b0;
					done_q      <= 1'b0;
					for (int k = 0; k < NUM_CV; k++)
						cv_q[k] <= IV[k];
				end else
					idx_q <= idx_q + 3'd1;
			end
		end
	end

	assign digest_word = cv_q[idx_q];
	assign word_index  = idx_q;
	assign final_word  = (idx_q == IDX_LAST);

endmodule
